[hdl/lpr_pkg.sv]
`default_nettype none
package lpr_pkg;

  localparam int PAGE_W      = 16;
  localparam int FRAME_IDX_W = 3;
  localparam int FAULT_W     = 32;
  localparam int CFG_W       = 4;

  localparam logic [CFG_W-1:0] CFG_FRAMES_RESET = 4'd8;

  // commands from the sequencer to the frame datapath
  typedef struct packed {
    logic capture;
    logic decide;
    logic commit;
  } lpr_cmd_t;

endpackage
`default_nettype wire

[hdl/lpr_in_if.sv]
`default_nettype none
interface lpr_in_if import lpr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PAGE_W-1:0] page;
  logic              start_of_run;

  modport source (output valid, output page, output start_of_run, input ready);
  modport sink   (input valid, input page, input start_of_run, output ready);
endinterface
`default_nettype wire

[hdl/lpr_out_if.sv]
`default_nettype none
interface lpr_out_if import lpr_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   hit;
  logic [FRAME_IDX_W-1:0] frame_index;
  logic                   evicted_valid;
  logic [PAGE_W-1:0]      evicted_page;
  logic [FAULT_W-1:0]     fault_total;

  modport source (output valid, output hit, output frame_index, output evicted_valid,
                  output evicted_page, output fault_total, input ready);
  modport sink   (input valid, input hit, input frame_index, input evicted_valid,
                  input evicted_page, input fault_total, output ready);
endinterface
`default_nettype wire

[hdl/lru_page_replacement_core.sv]
// lru page replacement core
// in_ch carries one request word: page number and a start_of_run flag. a set
// start_of_run empties every frame and zeroes the fault count before the
// request is looked up. out_ch carries one result word per request: hit, the
// frame used, the evicted page (zero if none) and the saturating fault count.
// cfg_wr_en/cfg_wr_data write frames_in_use (reset 8); 0 acts as 1 and values
// above MAX_FRAMES act as MAX_FRAMES. write it only while no request is open.
// each word takes a compare pass over all frame registers (match, first
// empty, least recent rank) followed by an update pass that writes the
// frame, the ranks, the fault count and the output register.
// the next word is taken on the same edge the update pass commits, as long
// as the output register is free or being drained.
// if the receiver stalls, one result waits in the output register and the
// core holds the next request in its update pass until that slot frees.
// reset (rst_n low, synchronous) empties all frames, clears the fault count
// and the output valid flag, and sets frames_in_use to 8.
`default_nettype none
module lru_page_replacement_core import lpr_pkg::*; #(
  parameter int MAX_FRAMES = 8,
  parameter int PAGE_BITS  = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  lpr_in_if.sink                in_ch,
  lpr_out_if.source             out_ch,
  input  wire logic             cfg_wr_en,
  input  wire logic [CFG_W-1:0] cfg_wr_data
);

  lpr_cmd_t cmd;

  lpr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  lpr_dp #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_page           (in_ch.page),
    .in_start_of_run   (in_ch.start_of_run),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .out_hit           (out_ch.hit),
    .out_frame_index   (out_ch.frame_index),
    .out_evicted_valid (out_ch.evicted_valid),
    .out_evicted_page  (out_ch.evicted_page),
    .out_fault_total   (out_ch.fault_total)
  );

endmodule
`default_nettype wire

[hdl/lpr_ctrl.sv]
`default_nettype none
module lpr_ctrl import lpr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output lpr_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LOOK   = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;
  logic       accept;

  always_comb begin
    out_free    = !out_valid_r || out_ready;
    cmd.commit  = (state_r == ST_UPDATE) && out_free;
    cmd.decide  = (state_r == ST_LOOK);
    // a new word may enter on the same edge the previous result is committed
    in_ready    = (state_r == ST_IDLE) || cmd.commit;
    accept      = in_valid && in_ready;
    cmd.capture = accept;

    out_valid_nxt = cmd.commit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

    case (state_r)
      ST_IDLE: begin
        state_nxt = accept ? ST_LOOK : ST_IDLE;
      end
      ST_LOOK: begin
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (cmd.commit) begin
          state_nxt = accept ? ST_LOOK : ST_IDLE;
        end else begin
          state_nxt = ST_UPDATE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

[hdl/lpr_dp.sv]
`default_nettype none
module lpr_dp import lpr_pkg::*; #(
  parameter int MAX_FRAMES = 8,
  parameter int PAGE_BITS  = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire lpr_cmd_t               cmd,
  input  wire logic [PAGE_W-1:0]      in_page,
  input  wire logic                   in_start_of_run,
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_W-1:0]       cfg_wr_data,
  output logic                        out_hit,
  output logic [FRAME_IDX_W-1:0]      out_frame_index,
  output logic                        out_evicted_valid,
  output logic [PAGE_W-1:0]           out_evicted_page,
  output logic [FAULT_W-1:0]          out_fault_total
);

  localparam int FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int RW = FW;
  localparam int KW = $clog2(MAX_FRAMES + 1);
  localparam int CW = ($clog2(MAX_FRAMES + 1) > CFG_W) ? $clog2(MAX_FRAMES + 1) : CFG_W;

  // configuration
  logic [CFG_W-1:0] frames_r;

  // captured request
  logic [PAGE_BITS-1:0] req_page_r;
  logic                 req_start_r;

  // frame store
  logic [PAGE_BITS-1:0] frame_page_r [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] valid_r, valid_nxt;
  logic [RW-1:0]        rank_r [MAX_FRAMES];
  logic [RW-1:0]        rank_nxt [MAX_FRAMES];
  logic [KW-1:0]        cnt_r, cnt_nxt, cnt_base;
  logic [FAULT_W-1:0]   fault_r, fault_nxt, fault_base;

  // decision from the compare pass
  logic          dec_hit_r;
  logic          dec_fill_r;
  logic [FW-1:0] dec_f_r;
  logic [RW-1:0] dec_rank_r;

  // compare pass
  logic [CW-1:0]         n_frames;
  logic [MAX_FRAMES-1:0] in_range, eff_valid, hit_vec, empty_vec, lru_vec;
  logic [FW-1:0]         hit_idx, empty_idx, lru_idx, f_sel;
  logic                  any_hit, any_empty;

  logic [PAGE_BITS+PAGE_W-1:0]  page_wide;
  logic [PAGE_BITS+PAGE_W-1:0]  evp_wide;
  logic [FW+FRAME_IDX_W-1:0]    f_wide;

  assign page_wide = {{PAGE_BITS{1'b0}}, in_page};
  assign evp_wide  = {{PAGE_W{1'b0}}, frame_page_r[dec_f_r]};
  assign f_wide    = {{FRAME_IDX_W{1'b0}}, dec_f_r};

  always_comb begin
    if (frames_r == '0) begin
      n_frames = CW'(1);
    end else if (CW'(frames_r) > CW'(MAX_FRAMES)) begin
      n_frames = CW'(MAX_FRAMES);
    end else begin
      n_frames = CW'(frames_r);
    end

    for (int i = 0; i < MAX_FRAMES; i++) begin
      in_range[i]  = CW'(i) < n_frames;
      eff_valid[i] = valid_r[i] && !req_start_r;
      hit_vec[i]   = in_range[i] && eff_valid[i] && (frame_page_r[i] == req_page_r);
      empty_vec[i] = in_range[i] && !eff_valid[i];
      // least recent: no frame in range holds a smaller rank
      lru_vec[i]   = in_range[i];
      for (int j = 0; j < MAX_FRAMES; j++) begin
        if (in_range[j] && (rank_r[j] < rank_r[i])) begin
          lru_vec[i] = 1'b0;
        end
      end
    end

    hit_idx   = '0;
    empty_idx = '0;
    lru_idx   = '0;
    for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_idx = FW'(i);
      end
      if (empty_vec[i]) begin
        empty_idx = FW'(i);
      end
      if (lru_vec[i]) begin
        lru_idx = FW'(i);
      end
    end
    any_hit   = |hit_vec;
    any_empty = |empty_vec;

    if (any_hit) begin
      f_sel = hit_idx;
    end else if (any_empty) begin
      f_sel = empty_idx;
    end else begin
      f_sel = lru_idx;
    end
  end

  // update pass
  always_comb begin
    valid_nxt  = req_start_r ? '0 : valid_r;
    cnt_base   = req_start_r ? '0 : cnt_r;
    fault_base = req_start_r ? '0 : fault_r;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      rank_nxt[i] = req_start_r ? '0 : rank_r[i];
    end
    cnt_nxt = cnt_base;

    if (dec_hit_r || fault_base == '1) begin
      fault_nxt = fault_base;
    end else begin
      fault_nxt = fault_base + FAULT_W'(1);
    end

    if (dec_fill_r) begin
      valid_nxt[dec_f_r] = 1'b1;
      rank_nxt[dec_f_r]  = RW'(cnt_base);
      cnt_nxt            = KW'(cnt_base + KW'(1));
    end else begin
      // hit or eviction: move frame to most recently used
      for (int i = 0; i < MAX_FRAMES; i++) begin
        if (valid_nxt[i] && (rank_nxt[i] > dec_rank_r)) begin
          rank_nxt[i] = RW'(rank_nxt[i] - RW'(1));
        end
      end
      rank_nxt[dec_f_r] = RW'(cnt_base - KW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_r <= CFG_FRAMES_RESET;
      valid_r  <= '0;
      cnt_r    <= '0;
      fault_r  <= '0;
      for (int i = 0; i < MAX_FRAMES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        frames_r <= cfg_wr_data;
      end
      if (cmd.commit) begin
        valid_r <= valid_nxt;
        cnt_r   <= cnt_nxt;
        fault_r <= fault_nxt;
        for (int i = 0; i < MAX_FRAMES; i++) begin
          rank_r[i] <= rank_nxt[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_page_r  <= page_wide[PAGE_BITS-1:0];
      req_start_r <= in_start_of_run;
    end
    if (cmd.decide) begin
      dec_hit_r  <= any_hit;
      dec_fill_r <= !any_hit && any_empty;
      dec_f_r    <= f_sel;
      dec_rank_r <= rank_r[f_sel];
    end
    if (cmd.commit) begin
      frame_page_r[dec_f_r] <= req_page_r;
      out_hit               <= dec_hit_r;
      out_frame_index       <= f_wide[FRAME_IDX_W-1:0];
      out_evicted_valid     <= !dec_hit_r && !dec_fill_r;
      out_evicted_page      <= (!dec_hit_r && !dec_fill_r) ? evp_wide[PAGE_W-1:0] : '0;
      out_fault_total       <= fault_nxt;
    end
  end

endmodule
`default_nettype wire

[test/tb_lru_page_replacement_core.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb_lru_page_replacement_core import lpr_pkg::*; ();

  localparam int FRAME_SLOTS = 8;
  localparam int HOLD_CYCLES = 90;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic                   hit;
    logic [FRAME_IDX_W-1:0] frame_index;
    logic                   evicted_valid;
    logic [PAGE_W-1:0]      evicted_page;
    logic [FAULT_W-1:0]     fault_total;
  } lpr_result_t;

  // one directed request; the result fields only count when known is set
  typedef struct packed {
    logic [PAGE_W-1:0]      page;
    logic                   start_of_run;
    logic                   known;
    logic                   hit;
    logic [FRAME_IDX_W-1:0] frame_index;
    logic                   evicted_valid;
    logic [PAGE_W-1:0]      evicted_page;
    logic [FAULT_W-1:0]     fault_total;
  } request_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;

  lpr_in_if  in_ch ();
  lpr_out_if out_ch ();

  lru_page_replacement_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  // frame table mirror
  logic [PAGE_W-1:0]      frame_page  [FRAME_SLOTS];
  logic                   frame_valid [FRAME_SLOTS];
  logic [FRAME_IDX_W-1:0] frame_rank  [FRAME_SLOTS];
  logic [FAULT_W-1:0]     fault_count;
  logic [CFG_W-1:0]       frames_cfg;

  lpr_result_t  pending_results[$];
  request_row_t directed_rows[$];
  lpr_result_t  oldest;

  int mismatch_count = 0;
  int cycle_count = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_req = 1'b0;
  int hold_cnt = 0;

  task automatic clear_frames();
    for (int i = 0; i < FRAME_SLOTS; i++) begin
      frame_page[i]  = '0;
      frame_valid[i] = 1'b0;
      frame_rank[i]  = '0;
    end
    fault_count = '0;
  endtask

  // move frame f to most recently used, k valid frames
  task automatic make_newest(input int f, input int k);
    logic [FRAME_IDX_W-1:0] old_rank;
    old_rank = frame_rank[f];
    for (int i = 0; i < FRAME_SLOTS; i++)
      if (frame_valid[i] && frame_rank[i] > old_rank)
        frame_rank[i] = frame_rank[i] - 1'b1;
    frame_rank[f] = FRAME_IDX_W'(k - 1);
  endtask

  task automatic lru_lookup(input logic [PAGE_W-1:0] pg, input logic sor,
                            output lpr_result_t res);
    int n;
    int k;
    int f;
    logic found;
    res = '0;
    if (sor)
      clear_frames();
    n = int'(frames_cfg);
    if (n < 1)
      n = 1;
    if (n > FRAME_SLOTS)
      n = FRAME_SLOTS;
    k = 0;
    for (int i = 0; i < FRAME_SLOTS; i++)
      if (frame_valid[i])
        k++;
    f = 0;
    found = 1'b0;
    for (int i = 0; i < n; i++)
      if (!found && frame_valid[i] && frame_page[i] == pg) begin
        f = i;
        found = 1'b1;
      end
    if (found) begin
      res.hit = 1'b1;
      make_newest(f, k);
    end else begin
      if (fault_count != '1)
        fault_count = fault_count + 1'b1;
      for (int i = 0; i < n; i++)
        if (!found && !frame_valid[i]) begin
          f = i;
          found = 1'b1;
        end
      if (found) begin
        frame_valid[f] = 1'b1;
        frame_page[f]  = pg;
        frame_rank[f]  = FRAME_IDX_W'(k);
      end else begin
        // lowest-numbered frame wins a tie
        f = 0;
        for (int i = 1; i < n; i++)
          if (frame_rank[i] < frame_rank[f])
            f = i;
        res.evicted_valid = 1'b1;
        res.evicted_page  = frame_page[f];
        frame_page[f] = pg;
        make_newest(f, k);
      end
    end
    res.frame_index = FRAME_IDX_W'(f);
    res.fault_total = fault_count;
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
    mismatch_count++;
  endtask

  task automatic write_frames_in_use(input logic [CFG_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    frames_cfg = value;
  endtask

  task automatic send_request(input logic [PAGE_W-1:0] pg, input logic sor,
                              input logic use_fixed, input lpr_result_t fixed);
    lpr_result_t res;
    int gap;
    if ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      gap = $urandom_range(1, 5);
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.page         <= pg;
    in_ch.start_of_run <= sor;
    @(posedge clk);
    while (!in_ch.ready)
      @(posedge clk);
    lru_lookup(pg, sor, res);
    if (use_fixed)
      pending_results.push_back(fixed);
    else
      pending_results.push_back(res);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] frames, input int send_idle,
                           input int recv_stall, input int count, input bit hold_off);
    logic [PAGE_W-1:0] working_set[16];
    logic [PAGE_W-1:0] pg;
    logic sor;
    int set_size;
    write_frames_in_use(frames);
    idle_pct  = send_idle;
    stall_pct = recv_stall;
    set_size = $urandom_range(2, 14);
    for (int i = 0; i < 16; i++)
      working_set[i] = PAGE_W'($urandom);
    if (hold_off)
      hold_req = 1'b1;
    for (int j = 0; j < count; j++) begin
      sor = ($urandom_range(99) < 3);
      // mostly a small working set so hits and evictions both happen
      if ($urandom_range(99) < 80)
        pg = working_set[$urandom_range(set_size - 1)];
      else
        pg = PAGE_W'($urandom);
      send_request(pg, sor, 1'b0, '0);
    end
    wait_drained();
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_lru_page_replacement_core failed");
      $finish;
    end
  end

  // receiver: random stalls plus one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && hold_cnt < HOLD_CYCLES) begin
        out_ch.ready <= 1'b0;
        hold_cnt++;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", {31'd0, out_ch.hit}, 32'd0);
      end else begin
        oldest = pending_results.pop_front();
        if (out_ch.hit !== oldest.hit)
          report_mismatch("hit", {31'd0, out_ch.hit}, {31'd0, oldest.hit});
        if (out_ch.frame_index !== oldest.frame_index)
          report_mismatch("frame_index", 32'(out_ch.frame_index), 32'(oldest.frame_index));
        if (out_ch.evicted_valid !== oldest.evicted_valid)
          report_mismatch("evicted_valid", {31'd0, out_ch.evicted_valid},
                          {31'd0, oldest.evicted_valid});
        if (out_ch.evicted_page !== oldest.evicted_page)
          report_mismatch("evicted_page", 32'(out_ch.evicted_page),
                          32'(oldest.evicted_page));
        if (out_ch.fault_total !== oldest.fault_total)
          report_mismatch("fault_total", out_ch.fault_total, oldest.fault_total);
      end
    end
  end

  initial begin
    lpr_result_t fixed;
    request_row_t row;
    rst_n              <= 1'b0;
    cfg_wr_en          <= 1'b0;
    cfg_wr_data        <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.page         <= '0;
    in_ch.start_of_run <= 1'b0;
    clear_frames();
    frames_cfg = CFG_FRAMES_RESET;

    // page, start, known, hit, frame, evicted, evicted page, faults
    directed_rows.push_back('{16'h0000, 1'b1, 1'b1, 1'b0, 3'd0, 1'b0, 16'h0000, 32'd1});
    directed_rows.push_back('{16'hFFFF, 1'b0, 1'b1, 1'b0, 3'd1, 1'b0, 16'h0000, 32'd2});
    directed_rows.push_back('{16'h0000, 1'b0, 1'b1, 1'b1, 3'd0, 1'b0, 16'h0000, 32'd2});
    directed_rows.push_back('{16'h0001, 1'b0, 1'b1, 1'b0, 3'd2, 1'b0, 16'h0000, 32'd3});
    directed_rows.push_back('{16'h0002, 1'b0, 1'b1, 1'b0, 3'd3, 1'b0, 16'h0000, 32'd4});
    directed_rows.push_back('{16'h0003, 1'b0, 1'b1, 1'b0, 3'd4, 1'b0, 16'h0000, 32'd5});
    directed_rows.push_back('{16'h0004, 1'b0, 1'b1, 1'b0, 3'd5, 1'b0, 16'h0000, 32'd6});
    directed_rows.push_back('{16'h0005, 1'b0, 1'b1, 1'b0, 3'd6, 1'b0, 16'h0000, 32'd7});
    directed_rows.push_back('{16'h0006, 1'b0, 1'b1, 1'b0, 3'd7, 1'b0, 16'h0000, 32'd8});
    // table full: oldest frame goes first
    directed_rows.push_back('{16'h8000, 1'b0, 1'b1, 1'b0, 3'd1, 1'b1, 16'hFFFF, 32'd9});
    directed_rows.push_back('{16'hFFFF, 1'b0, 1'b1, 1'b0, 3'd0, 1'b1, 16'h0000, 32'd10});
    directed_rows.push_back('{16'h0001, 1'b0, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0000, 32'd0});
    directed_rows.push_back('{16'h0002, 1'b0, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0000, 32'd0});
    directed_rows.push_back('{16'h7FFF, 1'b0, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0000, 32'd0});
    directed_rows.push_back('{16'h0003, 1'b0, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0000, 32'd0});
    // start of run empties the table and zeroes the count
    directed_rows.push_back('{16'h5555, 1'b1, 1'b1, 1'b0, 3'd0, 1'b0, 16'h0000, 32'd1});
    directed_rows.push_back('{16'hAAAA, 1'b0, 1'b1, 1'b0, 3'd1, 1'b0, 16'h0000, 32'd2});
    // resident page still misses after a start of run
    directed_rows.push_back('{16'h5555, 1'b1, 1'b1, 1'b0, 3'd0, 1'b0, 16'h0000, 32'd1});
    directed_rows.push_back('{16'h5555, 1'b0, 1'b1, 1'b1, 3'd0, 1'b0, 16'h0000, 32'd1});

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < directed_rows.size(); i++) begin
      row = directed_rows[i];
      fixed = '{row.hit, row.frame_index, row.evicted_valid, row.evicted_page,
                row.fault_total};
      send_request(row.page, row.start_of_run, row.known, fixed);
    end
    wait_drained();

    // frame count changes carry state over between phases
    run_phase(4'd8,  0,  0,  150, 1'b0);
    run_phase(4'd1,  66, 0,  100, 1'b0);
    run_phase(4'd4,  0,  66, 150, 1'b0);
    run_phase(4'd0,  8,  8,  80,  1'b0);
    run_phase(4'd15, 0,  0,  150, 1'b1);
    run_phase(4'd3,  66, 0,  120, 1'b0);
    run_phase(4'd8,  0,  66, 150, 1'b0);
    run_phase(4'd6,  8,  8,  150, 1'b0);

    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("tb_lru_page_replacement_core passed");
    else
      $display("tb_lru_page_replacement_core failed");
    $finish;
  end

endmodule
`default_nettype wire
